FILE: hw/rtl/nsbd_pkg.sv
// Package: nibble tables and the round mixing function of the block decipher.
`default_nettype none

package nsbd_pkg;

  typedef logic [3:0]  nib_t;
  typedef logic [63:0] blk_t;

  localparam int unsigned BlkW   = 64;
  localparam int unsigned NibCnt = 16;

  // Output nibble i takes input nibble NIB_PERM[i].
  localparam nib_t NIB_PERM [NibCnt] = '{
    4'd10, 4'd11, 4'd3, 4'd0, 4'd6, 4'd7, 4'd9, 4'd13,
    4'd15, 4'd8, 4'd14, 4'd12, 4'd5, 4'd4, 4'd1, 4'd2
  };

  // Row k substitutes nibble k.
  localparam nib_t NIB_SUB [NibCnt][NibCnt] = '{
    '{4'd8, 4'd9, 4'd5, 4'd12, 4'd13, 4'd2, 4'd10, 4'd3,
      4'd1, 4'd7, 4'd15, 4'd14, 4'd4, 4'd11, 4'd6, 4'd0},
    '{4'd5, 4'd6, 4'd0, 4'd9, 4'd11, 4'd14, 4'd3, 4'd15,
      4'd7, 4'd12, 4'd10, 4'd13, 4'd1, 4'd8, 4'd2, 4'd4},
    '{4'd7, 4'd13, 4'd1, 4'd14, 4'd5, 4'd0, 4'd10, 4'd15,
      4'd11, 4'd2, 4'd9, 4'd12, 4'd4, 4'd6, 4'd8, 4'd3},
    '{4'd8, 4'd12, 4'd2, 4'd11, 4'd9, 4'd6, 4'd3, 4'd4,
      4'd5, 4'd7, 4'd13, 4'd14, 4'd10, 4'd1, 4'd15, 4'd0},
    '{4'd7, 4'd11, 4'd2, 4'd14, 4'd10, 4'd0, 4'd9, 4'd6,
      4'd8, 4'd15, 4'd5, 4'd3, 4'd13, 4'd4, 4'd1, 4'd12},
    '{4'd8, 4'd10, 4'd1, 4'd13, 4'd14, 4'd4, 4'd6, 4'd12,
      4'd0, 4'd5, 4'd3, 4'd9, 4'd7, 4'd11, 4'd15, 4'd2},
    '{4'd2, 4'd13, 4'd6, 4'd9, 4'd4, 4'd11, 4'd14, 4'd7,
      4'd1, 4'd3, 4'd10, 4'd5, 4'd8, 4'd12, 4'd0, 4'd15},
    '{4'd12, 4'd0, 4'd13, 4'd10, 4'd1, 4'd8, 4'd14, 4'd6,
      4'd2, 4'd11, 4'd3, 4'd5, 4'd15, 4'd4, 4'd7, 4'd9},
    '{4'd11, 4'd9, 4'd5, 4'd1, 4'd8, 4'd0, 4'd12, 4'd13,
      4'd3, 4'd15, 4'd7, 4'd4, 4'd2, 4'd10, 4'd6, 4'd14},
    '{4'd1, 4'd12, 4'd9, 4'd14, 4'd5, 4'd13, 4'd0, 4'd8,
      4'd10, 4'd15, 4'd11, 4'd2, 4'd6, 4'd4, 4'd3, 4'd7},
    '{4'd7, 4'd5, 4'd10, 4'd12, 4'd9, 4'd1, 4'd8, 4'd14,
      4'd15, 4'd11, 4'd2, 4'd0, 4'd6, 4'd13, 4'd3, 4'd4},
    '{4'd3, 4'd11, 4'd1, 4'd14, 4'd7, 4'd12, 4'd15, 4'd0,
      4'd5, 4'd10, 4'd2, 4'd9, 4'd8, 4'd13, 4'd4, 4'd6},
    '{4'd8, 4'd5, 4'd12, 4'd9, 4'd1, 4'd4, 4'd14, 4'd0,
      4'd10, 4'd3, 4'd13, 4'd7, 4'd6, 4'd15, 4'd11, 4'd2},
    '{4'd3, 4'd6, 4'd11, 4'd5, 4'd1, 4'd8, 4'd14, 4'd10,
      4'd2, 4'd0, 4'd4, 4'd12, 4'd7, 4'd15, 4'd13, 4'd9},
    '{4'd12, 4'd7, 4'd11, 4'd6, 4'd2, 4'd1, 4'd14, 4'd3,
      4'd5, 4'd0, 4'd15, 4'd9, 4'd10, 4'd8, 4'd4, 4'd13},
    '{4'd7, 4'd8, 4'd15, 4'd5, 4'd13, 4'd4, 4'd12, 4'd11,
      4'd10, 4'd0, 4'd1, 4'd2, 4'd9, 4'd3, 4'd14, 4'd6}
  };

  // Permute the nibbles, then substitute each one through its own row.
  function automatic blk_t round_mix(blk_t blk);
    blk_t res;
    nib_t nib;
    res = '0;
    for (int i = 0; i < NibCnt; i++) begin
      nib = blk[4*int'(NIB_PERM[i]) +: 4];
      res[4*i +: 4] = NIB_SUB[i][nib];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/nsbd_if.sv
// Interfaces: valid/ready channels for cipher and plain words.
`default_nettype none

interface nsbd_in_if;
  logic                valid;
  logic                ready;
  logic [nsbd_pkg::BlkW-1:0] cipher_block;

  modport source (output valid, output cipher_block, input ready);
  modport sink   (input valid, input cipher_block, output ready);
endinterface

interface nsbd_out_if;
  logic                valid;
  logic                ready;
  logic [nsbd_pkg::BlkW-1:0] plain_block;

  modport source (output valid, output plain_block, input ready);
  modport sink   (input valid, input plain_block, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/nibble_sbox_block_decipher_top.sv
// Top level: key register, APB port and the unrolled round pipeline.
//
//  channel   dir  handshake       payload
//  in_i      in   valid/ready     cipher_block [63:0]
//  out_o     out  valid/ready     plain_block  [63:0]
//  apb       in   psel/penable    cipher_key at byte address 0
//
// One word enters per cycle while the output is ready or a stage is empty;
// one round per register stage. Reset clears the key and all stage valid bits.
// A stalled output holds its word; empty stages ahead of it still fill, so
// words keep entering until every stage holds one.
`default_nettype none

module nibble_sbox_block_decipher_top #(
  parameter int unsigned ROUND_COUNT = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  nsbd_in_if.sink               in_i,
  nsbd_out_if.source            out_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [63:0]      pwdata,
  output logic      [63:0]      prdata,
  output logic                  pready
);

  nsbd_pkg::blk_t key_q;
  nsbd_pkg::blk_t key_d;
  logic           key_sel;

  logic [ROUND_COUNT-1:0] vld;
  nsbd_pkg::blk_t         blk [ROUND_COUNT];
  logic [ROUND_COUNT:0]   adv;

  // Register 0 sits at byte offset 0; paddr[3] set is beyond the map.
  assign key_sel = (paddr[3] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = key_sel ? key_q : '0;

  always_comb begin
    key_d = key_q;
    if (psel && penable && pwrite && key_sel) begin
      key_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  // A stage loads when it is empty or its word moves on.
  assign adv[ROUND_COUNT] = out_o.ready;

  for (genvar s = 0; s < ROUND_COUNT; s++) begin : g_stage
    assign adv[s] = ~vld[s] | adv[s+1];

    if (s == 0) begin : g_first
      nsbd_round #(.STAGE(s)) u_round (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .adv_i  (adv[s]),
        .vld_i  (in_i.valid),
        .blk_i  (in_i.cipher_block),
        .key_i  (key_q),
        .vld_o  (vld[s]),
        .blk_o  (blk[s])
      );
    end else begin : g_next
      nsbd_round #(.STAGE(s)) u_round (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .adv_i  (adv[s]),
        .vld_i  (vld[s-1]),
        .blk_i  (blk[s-1]),
        .key_i  (key_q),
        .vld_o  (vld[s]),
        .blk_o  (blk[s])
      );
    end
  end

  assign in_i.ready        = adv[0];
  assign out_o.valid       = vld[ROUND_COUNT-1];
  assign out_o.plain_block = blk[ROUND_COUNT-1];

  // An accepted word lands in the first stage.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld[0])
    else $error("accepted word missing from first stage");

  // Any empty stage opens the input.
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&vld) |-> in_i.ready)
    else $error("input stalled with an empty stage");

  // A full pipeline with a stalled output takes nothing.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&vld) && !out_o.ready |-> !in_i.ready)
    else $error("input taken while pipeline full and stalled");

  // A stalled first stage keeps its word.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[0] && !adv[0] |=> vld[0] && $stable(blk[0]))
    else $error("stalled first stage lost its word");

endmodule

`default_nettype wire

FILE: hw/rtl/nsbd_round.sv
// One registered decipher round: permute, substitute, mix in the rotated key.
`default_nettype none

module nsbd_round #(
  parameter int unsigned STAGE = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              vld_i,
  input  wire nsbd_pkg::blk_t    blk_i,
  input  wire nsbd_pkg::blk_t    key_i,
  output logic                   vld_o,
  output nsbd_pkg::blk_t         blk_o
);

  localparam int unsigned Rot = (4 * (STAGE + 1)) % nsbd_pkg::BlkW;

  logic [2*nsbd_pkg::BlkW-1:0] key_dbl;
  nsbd_pkg::blk_t              rkey;
  nsbd_pkg::blk_t              blk_d;
  nsbd_pkg::blk_t              blk_q;
  logic                        vld_q;

  // Rotate right by a fixed amount per stage.
  assign key_dbl = {key_i, key_i} >> Rot;
  assign rkey    = key_dbl[nsbd_pkg::BlkW-1:0];
  assign blk_d   = nsbd_pkg::round_mix(blk_i) ^ rkey;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && vld_i) begin
      blk_q <= blk_d;
    end
  end

  assign vld_o = vld_q;
  assign blk_o = blk_q;

endmodule

`default_nettype wire
